// File: rtl/setq_pkg.sv
package setq_pkg;

  localparam int SLOTS  = 16;
  localparam int ID_W   = 4;
  localparam int CNT_W  = 5;
  localparam int TIME_W = 32;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_ADJUST = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_TICK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BUSY_ID = 2'd1,
    STAT_NO_ID   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INS_RD,
    S_INS_CMP,
    S_ACK,
    S_TK_RD,
    S_TK_CMP,
    S_TK_DONE
  } state_t;

  // One operation on the ordered id list per cycle
  typedef struct packed {
    logic             insert;
    logic             remove_id;
    logic             pop;
    logic [CNT_W-1:0] pos;
    logic [ID_W-1:0]  id;
  } order_op_t;

endpackage

// File: rtl/setq_order.sv
module setq_order (
  input  logic                           clk,
  input  logic                           rst_n,
  input  setq_pkg::order_op_t            op,
  output logic [setq_pkg::CNT_W-1:0]     count,
  output logic [setq_pkg::ID_W-1:0]      head,
  output logic [setq_pkg::ID_W-1:0]      entry
);

  logic [setq_pkg::ID_W-1:0]  order_r   [setq_pkg::SLOTS];
  logic [setq_pkg::ID_W-1:0]  order_nxt [setq_pkg::SLOTS];
  logic [setq_pkg::CNT_W-1:0] count_r;
  logic [setq_pkg::CNT_W-1:0] count_nxt;
  logic [setq_pkg::SLOTS-1:0] match;
  logic [setq_pkg::CNT_W-1:0] mpos;
  logic [setq_pkg::CNT_W-1:0] rpos;
  logic                       do_rm;

  assign count = count_r;
  assign head  = order_r[0];
  assign entry = order_r[op.pos[setq_pkg::ID_W-1:0]];

  // Locate the id among valid entries; ids are unique so at most one hits
  always_comb begin
    mpos = '0;
    for (int i = 0; i < setq_pkg::SLOTS; i++) begin
      match[i] = (setq_pkg::CNT_W'(i) < count_r) && (order_r[i] == op.id);
      if (match[i]) begin
        mpos = mpos | setq_pkg::CNT_W'(i);
      end
    end
  end

  // Shift entries to close a gap or open one
  always_comb begin
    order_nxt = order_r;
    count_nxt = count_r;
    rpos      = op.pop ? '0 : mpos;
    do_rm     = op.pop ? (count_r != '0) : (op.remove_id && (|match));
    if (do_rm) begin
      for (int i = 0; i < setq_pkg::SLOTS - 1; i++) begin
        if (setq_pkg::CNT_W'(i) >= rpos) begin
          order_nxt[i] = order_r[i+1];
        end
      end
      count_nxt = count_r - 1'b1;
    end else if (op.insert) begin
      for (int i = 1; i < setq_pkg::SLOTS; i++) begin
        if (setq_pkg::CNT_W'(i) > op.pos) begin
          order_nxt[i] = order_r[i-1];
        end
      end
      order_nxt[op.pos[setq_pkg::ID_W-1:0]] = op.id;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    order_r <= order_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/sorted_expiry_timer_queue.sv
// Delete and rejected requests are checked, then acknowledged; add and adjust walk the list
// past each queued timer at or before the new expiry, stopping at a later timer or the end.
// Tick expires front timers in order until an unexpired timer or an empty queue ends the walk.
// One request at a time: the next one is taken the cycle after its last result issues.
// Reset (synchronous, rst_n low) empties the queue and clears all slot-used bits;
// the expiry and data memories are not cleared.
module sorted_expiry_timer_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_action,
  input  logic [setq_pkg::ID_W-1:0]      in_timer_id,
  input  logic [setq_pkg::TIME_W-1:0]    in_expire_time,
  input  logic [setq_pkg::DATA_W-1:0]    in_user_data,
  input  logic [setq_pkg::TIME_W-1:0]    in_now_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_kind,
  output logic [1:0]                     out_status,
  output logic [setq_pkg::ID_W-1:0]      out_expired_id,
  output logic [setq_pkg::DATA_W-1:0]    out_expired_data,
  output logic                           out_last
);

  setq_pkg::state_t              state_r, state_nxt;
  setq_pkg::action_t             act_r;
  logic [setq_pkg::ID_W-1:0]     id_r;
  logic [setq_pkg::TIME_W-1:0]   exp_r;
  logic [setq_pkg::DATA_W-1:0]   data_r;
  logic [setq_pkg::TIME_W-1:0]   now_r;
  setq_pkg::status_t             status_r, status_nxt;
  logic [setq_pkg::CNT_W-1:0]    pos_r, pos_nxt;
  logic [setq_pkg::SLOTS-1:0]    used_r, used_nxt;

  logic [setq_pkg::TIME_W-1:0]   exp_mem  [setq_pkg::SLOTS];
  logic [setq_pkg::DATA_W-1:0]   data_mem [setq_pkg::SLOTS];
  logic [setq_pkg::TIME_W-1:0]   rd_exp_r;
  logic [setq_pkg::DATA_W-1:0]   rd_data_r;
  logic                          rd_en;
  logic [setq_pkg::ID_W-1:0]     rd_addr;
  logic                          wr_exp;
  logic                          wr_data;
  logic [setq_pkg::TIME_W-1:0]   cmp_ref;
  logic                          cmp_le;

  setq_pkg::order_op_t           op;
  logic [setq_pkg::CNT_W-1:0]    count;
  logic [setq_pkg::ID_W-1:0]     head;
  logic [setq_pkg::ID_W-1:0]     entry;

  logic                          out_valid_r;
  setq_pkg::kind_t               out_kind_r;
  setq_pkg::status_t             out_status_r;
  logic [setq_pkg::ID_W-1:0]     out_id_r;
  logic [setq_pkg::DATA_W-1:0]   out_data_r;
  logic                          out_last_r;

  logic                          in_accept;
  logic                          emit_ok;
  logic                          emit;
  setq_pkg::kind_t               emit_kind;
  setq_pkg::status_t             emit_status;
  logic [setq_pkg::ID_W-1:0]     emit_id;
  logic [setq_pkg::DATA_W-1:0]   emit_data;
  logic                          emit_last;

  assign in_stall         = (state_r != setq_pkg::S_IDLE);
  assign in_accept        = in_valid && !in_stall;
  assign emit_ok          = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_status       = out_status_r;
  assign out_expired_id   = out_id_r;
  assign out_expired_data = out_data_r;
  assign out_last         = out_last_r;

  // Share one expiry compare between the insertion walk and the tick
  assign cmp_ref = (act_r == setq_pkg::ACT_TICK) ? now_r : exp_r;
  assign cmp_le  = (rd_exp_r <= cmp_ref);

  setq_order u_order (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .count (count),
    .head  (head),
    .entry (entry)
  );

  // Sequencer: next state, list operations, memory access and results
  always_comb begin
    state_nxt   = state_r;
    status_nxt  = status_r;
    pos_nxt     = pos_r;
    used_nxt    = used_r;
    op          = '0;
    op.pos      = pos_r;
    op.id       = id_r;
    rd_en       = 1'b0;
    rd_addr     = entry;
    wr_exp      = 1'b0;
    wr_data     = 1'b0;
    emit        = 1'b0;
    emit_kind   = setq_pkg::KIND_ACK;
    emit_status = status_r;
    emit_id     = id_r;
    emit_data   = '0;
    emit_last   = 1'b1;
    case (state_r)
      setq_pkg::S_IDLE: begin
        if (in_accept) begin
          status_nxt = setq_pkg::STAT_OK;
          pos_nxt    = '0;
          if (setq_pkg::action_t'(in_action) == setq_pkg::ACT_TICK) begin
            state_nxt = setq_pkg::S_TK_RD;
          end else begin
            state_nxt = setq_pkg::S_CHECK;
          end
        end
      end
      setq_pkg::S_CHECK: begin
        case (act_r)
          setq_pkg::ACT_ADD: begin
            if (used_r[id_r]) begin
              status_nxt = setq_pkg::STAT_BUSY_ID;
              state_nxt  = setq_pkg::S_ACK;
            end else begin
              wr_exp       = 1'b1;
              wr_data      = 1'b1;
              used_nxt[id_r] = 1'b1;
              state_nxt    = setq_pkg::S_INS_RD;
            end
          end
          setq_pkg::ACT_ADJUST: begin
            if (!used_r[id_r]) begin
              status_nxt = setq_pkg::STAT_NO_ID;
              state_nxt  = setq_pkg::S_ACK;
            end else begin
              op.remove_id = 1'b1;
              wr_exp       = 1'b1;
              state_nxt    = setq_pkg::S_INS_RD;
            end
          end
          default: begin
            if (!used_r[id_r]) begin
              status_nxt = setq_pkg::STAT_NO_ID;
            end else begin
              op.remove_id   = 1'b1;
              used_nxt[id_r] = 1'b0;
            end
            state_nxt = setq_pkg::S_ACK;
          end
        endcase
      end
      // Walk the list until an entry expires later than the new one or the list ends
      setq_pkg::S_INS_RD: begin
        if (pos_r == count) begin
          op.insert = 1'b1;
          state_nxt = setq_pkg::S_ACK;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = entry;
          state_nxt = setq_pkg::S_INS_CMP;
        end
      end
      setq_pkg::S_INS_CMP: begin
        if (cmp_le) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = setq_pkg::S_INS_RD;
        end else begin
          op.insert = 1'b1;
          state_nxt = setq_pkg::S_ACK;
        end
      end
      setq_pkg::S_ACK: begin
        emit = emit_ok;
        if (emit_ok) begin
          state_nxt = setq_pkg::S_IDLE;
        end
      end
      // Fetch the front timer, or finish if the queue is empty
      setq_pkg::S_TK_RD: begin
        if (count == '0) begin
          state_nxt = setq_pkg::S_TK_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head;
          state_nxt = setq_pkg::S_TK_CMP;
        end
      end
      // Expire the front timer or stop
      setq_pkg::S_TK_CMP: begin
        if (!cmp_le) begin
          state_nxt = setq_pkg::S_TK_DONE;
        end else if (emit_ok) begin
          emit           = 1'b1;
          emit_kind      = setq_pkg::KIND_EXPIRED;
          emit_status    = setq_pkg::STAT_OK;
          emit_id        = head;
          emit_data      = rd_data_r;
          emit_last      = 1'b0;
          used_nxt[head] = 1'b0;
          op.pop         = 1'b1;
          state_nxt      = setq_pkg::S_TK_RD;
        end
      end
      setq_pkg::S_TK_DONE: begin
        emit        = emit_ok;
        emit_kind   = setq_pkg::KIND_DONE;
        emit_status = setq_pkg::STAT_OK;
        emit_id     = '0;
        if (emit_ok) begin
          state_nxt = setq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = setq_pkg::S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= setq_pkg::S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request and working registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r  <= setq_pkg::action_t'(in_action);
      id_r   <= in_timer_id;
      exp_r  <= in_expire_time;
      data_r <= in_user_data;
      now_r  <= in_now_time;
    end
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r   <= emit_kind;
      out_status_r <= emit_status;
      out_id_r     <= emit_id;
      out_data_r   <= emit_data;
      out_last_r   <= emit_last;
    end
  end

  // Expiry and data memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_exp) begin
      exp_mem[id_r] <= exp_r;
    end
    if (wr_data) begin
      data_mem[id_r] <= data_r;
    end
    if (rd_en) begin
      rd_exp_r  <= exp_mem[rd_addr];
      rd_data_r <= data_mem[rd_addr];
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import setq_pkg::*;

  typedef struct packed {
    action_t             act;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   expire;
    logic [DATA_W-1:0]   data;
    logic [TIME_W-1:0]   now;
  } timer_req_t;

  typedef struct packed {
    kind_t               kind;
    status_t             status;
    logic [ID_W-1:0]     id;
    logic [DATA_W-1:0]   data;
    logic                last;
  } timer_result_t;

  typedef struct packed {
    timer_req_t          req;
    bit                  typed;
    status_t             typed_status;
  } directed_row_t;

  localparam int RANDOM_PER_PHASE = 96;
  localparam int NUM_PHASES       = 5;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 60;

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [1:0]          in_action        = '0;
  logic [ID_W-1:0]     in_timer_id      = '0;
  logic [TIME_W-1:0]   in_expire_time   = '0;
  logic [DATA_W-1:0]   in_user_data     = '0;
  logic [TIME_W-1:0]   in_now_time      = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [1:0]          out_kind;
  logic [1:0]          out_status;
  logic [ID_W-1:0]     out_expired_id;
  logic [DATA_W-1:0]   out_expired_data;
  logic                out_last;

  // Timer queue shadow state
  logic [TIME_W-1:0]   timer_expiry  [SLOTS];
  logic [DATA_W-1:0]   timer_payload [SLOTS];
  bit                  timer_armed   [SLOTS];
  logic [ID_W-1:0]     expiry_order[$];

  timer_result_t       expected_timer_results[$];
  directed_row_t       directed_rows[$];

  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  hold_len       = 0;
  bit                  hold_go        = 1'b0;
  int                  mismatch_count = 0;
  int                  results_checked = 0;
  int                  requests_sent  = 0;
  int                  deepest_queue  = 0;
  int                  biggest_burst  = 0;
  int                  fill_left      = 0;
  logic [TIME_W-1:0]   wall_time      = '0;

  sorted_expiry_timer_queue i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_timer_id      (in_timer_id),
    .in_expire_time   (in_expire_time),
    .in_user_data     (in_user_data),
    .in_now_time      (in_now_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_status       (out_status),
    .out_expired_id   (out_expired_id),
    .out_expired_data (out_expired_data),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #20_000_000;
    $display("sorted_expiry_timer_queue regression: fail");
    $finish;
  end

  function automatic string fmt_result(input timer_result_t r);
    return $sformatf("kind %0d status %0d id %0d data %h last %0d",
                     r.kind, r.status, r.id, r.data, r.last);
  endfunction

  // Place a timer after every queued timer with an equal or earlier expiry
  function automatic void file_in_order(input logic [ID_W-1:0] id);
    int pos;
    pos = 0;
    while (pos < expiry_order.size() && timer_expiry[expiry_order[pos]] <= timer_expiry[id])
      pos++;
    expiry_order.insert(pos, id);
    if (expiry_order.size() > deepest_queue) deepest_queue = expiry_order.size();
  endfunction

  function automatic void drop_from_order(input logic [ID_W-1:0] id);
    for (int i = 0; i < expiry_order.size(); i++) begin
      if (expiry_order[i] == id) begin
        expiry_order.delete(i);
        break;
      end
    end
  endfunction

  // Advance the shadow queue by one request and queue the results it causes
  function automatic void predict_timer_results(input timer_req_t req, input bit emit);
    timer_result_t res;
    logic [ID_W-1:0] head;
    int n_expired;
    res.kind   = KIND_ACK;
    res.status = STAT_OK;
    res.id     = req.id;
    res.data   = '0;
    res.last   = 1'b1;
    n_expired  = 0;
    case (req.act)
      ACT_TICK: begin
        while (expiry_order.size() > 0 && timer_expiry[expiry_order[0]] <= req.now) begin
          head = expiry_order.pop_front();
          timer_armed[head] = 1'b0;
          res.kind = KIND_EXPIRED;
          res.id   = head;
          res.data = timer_payload[head];
          res.last = 1'b0;
          if (emit) expected_timer_results.push_back(res);
          n_expired++;
        end
        if (n_expired > biggest_burst) biggest_burst = n_expired;
        res.kind = KIND_DONE;
        res.id   = '0;
        res.data = '0;
        res.last = 1'b1;
      end
      ACT_ADD: begin
        if (timer_armed[req.id]) begin
          res.status = STAT_BUSY_ID;
        end else begin
          timer_expiry[req.id]  = req.expire;
          timer_payload[req.id] = req.data;
          timer_armed[req.id]   = 1'b1;
          file_in_order(req.id);
        end
      end
      ACT_ADJUST: begin
        if (!timer_armed[req.id]) begin
          res.status = STAT_NO_ID;
        end else begin
          drop_from_order(req.id);
          timer_expiry[req.id] = req.expire;
          file_in_order(req.id);
        end
      end
      default: begin
        if (!timer_armed[req.id]) begin
          res.status = STAT_NO_ID;
        end else begin
          drop_from_order(req.id);
          timer_armed[req.id] = 1'b0;
        end
      end
    endcase
    if (emit) expected_timer_results.push_back(res);
  endfunction

  function automatic logic [ID_W-1:0] choose_id(input bit want_armed);
    logic [ID_W-1:0] pool[$];
    for (int i = 0; i < SLOTS; i++)
      if (timer_armed[i] == want_armed) pool.push_back(ID_W'(i));
    if (pool.size() == 0) return ID_W'($urandom_range(SLOTS - 1));
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  // Build one random request, mostly well formed, with fill-and-drain bursts
  task automatic make_random_request(output timer_req_t req);
    int pick;
    req.act    = action_t'($urandom_range(3));
    req.id     = ID_W'($urandom_range(SLOTS - 1));
    req.expire = $urandom;
    req.data   = $urandom;
    req.now    = $urandom;
    if (fill_left == 0 && $urandom_range(39) == 0) fill_left = SLOTS + 1;
    pick = $urandom_range(99);
    if (fill_left > 1) begin
      req.act    = ACT_ADD;
      req.id     = choose_id(1'b0);
      req.expire = wall_time + $urandom_range(8);
      fill_left--;
    end else if (fill_left == 1) begin
      req.act = ACT_TICK;
      if ($urandom_range(1)) begin
        req.now = '1;
      end else begin
        wall_time = wall_time + 200;
        req.now   = wall_time;
      end
      fill_left = 0;
    end else if (pick < 8) begin
      // keep the noise request as drawn
    end else if (pick < 45) begin
      req.act = ACT_ADD;
      req.id  = (pick < 12) ? ID_W'($urandom_range(SLOTS - 1)) : choose_id(1'b0);
      if (pick >= 15) req.expire = wall_time + $urandom_range(30);
    end else if (pick < 62) begin
      req.act = ACT_ADJUST;
      req.id  = (pick < 48) ? ID_W'($urandom_range(SLOTS - 1)) : choose_id(1'b1);
      if (expiry_order.size() > 0 && $urandom_range(2) == 0)
        req.expire = timer_expiry[expiry_order[$urandom_range(expiry_order.size() - 1)]];
      else if (pick >= 50)
        req.expire = wall_time + $urandom_range(40);
    end else if (pick < 75) begin
      req.act = ACT_DELETE;
      req.id  = (pick < 65) ? ID_W'($urandom_range(SLOTS - 1)) : choose_id(1'b1);
    end else begin
      req.act = ACT_TICK;
      if (pick >= 98) begin
        req.now = '1;
      end else if (pick < 96) begin
        wall_time = wall_time + $urandom_range(12);
        req.now   = wall_time;
      end
    end
  endtask

  // Offer one request and record its expected results once it is taken
  task automatic offer_request(input timer_req_t req, input bit typed,
                               input status_t typed_status);
    timer_result_t ack;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= req.act;
    in_timer_id    <= req.id;
    in_expire_time <= req.expire;
    in_user_data   <= req.data;
    in_now_time    <= req.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_timer_results(req, !typed);
    if (typed) begin
      ack.kind   = (req.act == ACT_TICK) ? KIND_DONE : KIND_ACK;
      ack.status = typed_status;
      ack.id     = (req.act == ACT_TICK) ? '0 : req.id;
      ack.data   = '0;
      ack.last   = 1'b1;
      expected_timer_results.push_back(ack);
    end
    requests_sent++;
  endtask

  task automatic add_row(input action_t act, input logic [ID_W-1:0] id,
                         input logic [TIME_W-1:0] expire, input logic [DATA_W-1:0] data,
                         input logic [TIME_W-1:0] now, input bit typed,
                         input status_t typed_status);
    directed_row_t row;
    row.req.act      = act;
    row.req.id       = id;
    row.req.expire   = expire;
    row.req.data     = data;
    row.req.now      = now;
    row.typed        = typed;
    row.typed_status = typed_status;
    directed_rows.push_back(row);
  endtask

  // Drive the result-side stall, with one long hold-off on request
  initial begin : stall_gen
    int hold_cnt;
    bit hold_seen;
    hold_cnt  = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_cnt  = hold_len;
      end
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
        hold_cnt--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Check each taken result against the oldest expectation
  always @(posedge clk) begin : result_check
    timer_result_t got;
    timer_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind   = kind_t'(out_kind);
      got.status = status_t'(out_status);
      got.id     = out_expired_id;
      got.data   = out_expired_data;
      got.last   = out_last;
      results_checked++;
      if (expected_timer_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing expected: %s", $realtime, fmt_result(got));
      end else begin
        want = expected_timer_results.pop_front();
        if (got.kind !== want.kind || got.status !== want.status || got.id !== want.id ||
            got.data !== want.data || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
        end
      end
    end
  end

  initial begin : stimulus
    timer_req_t req;

    // Directed requests: empty queue, errors, ties, re-sorts, extremes
    add_row(ACT_TICK,   4'd0,  32'd0,          32'd0,          32'd0,          1'b1, STAT_OK);
    add_row(ACT_DELETE, 4'd5,  32'd0,          32'd0,          32'd0,          1'b1, STAT_NO_ID);
    add_row(ACT_ADJUST, 4'd0,  32'd16,         32'd0,          32'd0,          1'b1, STAT_NO_ID);
    add_row(ACT_ADD,    4'd0,  32'd0,          32'd0,          32'd0,          1'b1, STAT_OK);
    add_row(ACT_ADD,    4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, STAT_OK);
    add_row(ACT_ADD,    4'd0,  32'd5,          32'd1,          32'd0,          1'b1, STAT_BUSY_ID);
    add_row(ACT_ADD,    4'd3,  32'd100,        32'hA5A5_A5A5,  32'd0,          1'b1, STAT_OK);
    add_row(ACT_ADD,    4'd4,  32'd100,        32'h5A5A_5A5A,  32'd0,          1'b1, STAT_OK);
    add_row(ACT_ADD,    4'd7,  32'd50,         32'h1234_5678,  32'd0,          1'b1, STAT_OK);
    add_row(ACT_ADJUST, 4'd3,  32'd100,        32'd0,          32'd0,          1'b1, STAT_OK);
    add_row(ACT_ADJUST, 4'd4,  32'd10,         32'd0,          32'd0,          1'b1, STAT_OK);
    add_row(ACT_ADJUST, 4'd7,  32'd200,        32'd0,          32'd0,          1'b1, STAT_OK);
    add_row(ACT_TICK,   4'd0,  32'd0,          32'd0,          32'd9,          1'b0, STAT_OK);
    add_row(ACT_DELETE, 4'd0,  32'd0,          32'd0,          32'd0,          1'b1, STAT_NO_ID);
    add_row(ACT_TICK,   4'd0,  32'd0,          32'd0,          32'd99,         1'b0, STAT_OK);
    add_row(ACT_TICK,   4'd0,  32'd0,          32'd0,          32'd100,        1'b0, STAT_OK);
    add_row(ACT_DELETE, 4'd7,  32'd0,          32'd0,          32'd0,          1'b1, STAT_OK);
    add_row(ACT_ADD,    4'd8,  32'h8000_0000,  32'h0F0F_0F0F,  32'd0,          1'b1, STAT_OK);
    add_row(ACT_ADD,    4'd9,  32'h8000_0000,  32'hF0F0_F0F0,  32'd0,          1'b1, STAT_OK);
    add_row(ACT_DELETE, 4'd15, 32'd0,          32'd0,          32'd0,          1'b1, STAT_OK);
    add_row(ACT_DELETE, 4'd8,  32'd0,          32'd0,          32'd0,          1'b1, STAT_OK);
    add_row(ACT_TICK,   4'd0,  32'd0,          32'd0,          32'hFFFF_FFFF,  1'b0, STAT_OK);
    add_row(ACT_TICK,   4'd0,  32'd0,          32'd0,          32'hFFFF_FFFF,  1'b1, STAT_OK);

    // Hold reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].typed_status);

    // Random requests across idle and stall profiles
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        3: begin send_idle_pct = 20; recv_stall_pct = 20; end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_len       = HOLD_CYCLES;
          hold_go        = ~hold_go;
        end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        make_random_request(req);
        offer_request(req, 1'b0, STAT_OK);
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results
    recv_stall_pct = 0;
    while (expected_timer_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results; deepest queue %0d of %0d timers.",
             requests_sent, results_checked, deepest_queue, SLOTS);
    $display("Largest expiry burst %0d timers; %0d mismatches.", biggest_burst, mismatch_count);
    if (mismatch_count == 0) begin
      $display("sorted_expiry_timer_queue regression: pass");
    end else begin
      $display("sorted_expiry_timer_queue regression: fail");
    end
    $finish;
  end

endmodule
